// File: hdl/iss_pkg.sv
// Shared types, constants and register codes of the irrigation stage sequencer.
package iss_pkg;

    localparam int POT_COUNT = 4;
    localparam int NUM_POTS = (POT_COUNT < 4) ? POT_COUNT : 4;
    localparam int NUM_TARGETS = 5;
    localparam int HUMID_BIT = 4;
    localparam logic [2:0] HUMID_CODE = 3'd5;
    localparam logic [15:0] SETTLE_SEC = 16'd10;
    localparam logic [15:0] SAT_MAX = 16'hFFFF;
    localparam logic [4:0] PEND_MASK = 5'((1 << NUM_POTS) - 1) | 5'(1 << HUMID_BIT);
    localparam int ITEM_W = 38;
    localparam int RES_W = 10;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_MIX     = 3'd1,
        ST_VALVE   = 3'd2,
        ST_TEST    = 3'd3,
        ST_SETTLE  = 3'd4,
        ST_RECHECK = 3'd5,
        ST_MAIN    = 3'd6
    } t_stage;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_FINISHED = 2'd1,
        EV_RECHECK  = 2'd2,
        EV_ABORT    = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        REG_AUTO_ENABLE    = 3'd0,
        REG_MOISTURE_MIN   = 3'd1,
        REG_RISE_THRESHOLD = 3'd2,
        REG_MIN_INTERVAL   = 3'd3,
        REG_MIX_SEC        = 3'd4,
        REG_TEST_SEC       = 3'd5,
        REG_MAIN_SEC       = 3'd6,
        REG_HUMID_MAIN_SEC = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]      request_pulses;
        logic            wrap_near;
        logic            valve_feedback;
        logic            humidifier_has_water;
        logic            leak_detected;
        logic            reservoir_has_water;
        logic [3:0][6:0] pot_moisture;
    } t_item;

    typedef struct packed {
        t_event     event_res;
        t_stage     stage;
        logic [2:0] valve_target;
        logic       pump_on;
        logic       mixer_on;
    } t_result;

    typedef struct packed {
        logic        auto_enable;
        logic [6:0]  moisture_min;
        logic [6:0]  rise_threshold;
        logic [15:0] min_interval_sec;
        logic [15:0] mix_sec;
        logic [15:0] test_sec;
        logic [15:0] main_sec;
        logic [15:0] humid_main_sec;
    } t_cfg;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
        logic [6:0] moist;
    } t_sel;

endpackage

// File: hdl/iss_cfg.sv
// Configuration register file with its APB-style access port.
module iss_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iss_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [iss_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [iss_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output iss_pkg::t_cfg                  o_cfg
);
    import iss_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_enable      <= 1'b0;
            r_cfg.moisture_min     <= 7'd30;
            r_cfg.rise_threshold   <= 7'd10;
            r_cfg.min_interval_sec <= 16'd300;
            r_cfg.mix_sec          <= 16'd30;
            r_cfg.test_sec         <= 16'd30;
            r_cfg.main_sec         <= 16'd30;
            r_cfg.humid_main_sec   <= 16'd300;
        end else if (w_wr) begin
            case (w_idx)
                REG_AUTO_ENABLE:    r_cfg.auto_enable      <= pwdata[0];
                REG_MOISTURE_MIN:   r_cfg.moisture_min     <= pwdata[6:0];
                REG_RISE_THRESHOLD: r_cfg.rise_threshold   <= pwdata[6:0];
                REG_MIN_INTERVAL:   r_cfg.min_interval_sec <= pwdata[15:0];
                REG_MIX_SEC:        r_cfg.mix_sec          <= pwdata[15:0];
                REG_TEST_SEC:       r_cfg.test_sec         <= pwdata[15:0];
                REG_MAIN_SEC:       r_cfg.main_sec         <= pwdata[15:0];
                REG_HUMID_MAIN_SEC: r_cfg.humid_main_sec   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_AUTO_ENABLE:    prdata = {31'd0, r_cfg.auto_enable};
            REG_MOISTURE_MIN:   prdata = {25'd0, r_cfg.moisture_min};
            REG_RISE_THRESHOLD: prdata = {25'd0, r_cfg.rise_threshold};
            REG_MIN_INTERVAL:   prdata = {16'd0, r_cfg.min_interval_sec};
            REG_MIX_SEC:        prdata = {16'd0, r_cfg.mix_sec};
            REG_TEST_SEC:       prdata = {16'd0, r_cfg.test_sec};
            REG_MAIN_SEC:       prdata = {16'd0, r_cfg.main_sec};
            REG_HUMID_MAIN_SEC: prdata = {16'd0, r_cfg.humid_main_sec};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hdl/iss_select.sv
// Target selection: latched requests first, then dry pots, then an empty humidifier tank.
module iss_select (
    input  iss_pkg::t_cfg   i_cfg,
    input  iss_pkg::t_item  i_item,
    input  logic [4:0]      i_pend,
    input  logic [15:0]     i_since [iss_pkg::NUM_TARGETS],
    output iss_pkg::t_sel   o_sel
);
    import iss_pkg::*;

    always_comb begin
        o_sel = '0;
        for (int k = NUM_TARGETS - 1; k >= 0; k--) begin
            if (i_pend[k]) begin
                o_sel.hit = 1'b1;
                if (k == HUMID_BIT) begin
                    o_sel.code  = HUMID_CODE;
                    o_sel.moist = '0;
                end else begin
                    o_sel.code  = 3'(k + 1);
                    o_sel.moist = i_item.pot_moisture[2'(k)];
                end
            end
        end
        if (!o_sel.hit && i_cfg.auto_enable) begin
            if (!i_item.humidifier_has_water && i_since[HUMID_BIT] >= i_cfg.min_interval_sec) begin
                o_sel.hit   = 1'b1;
                o_sel.code  = HUMID_CODE;
                o_sel.moist = '0;
            end
            for (int k = NUM_POTS - 1; k >= 0; k--) begin
                if (i_item.pot_moisture[k] < i_cfg.moisture_min
                        && i_since[k] >= i_cfg.min_interval_sec) begin
                    o_sel.hit   = 1'b1;
                    o_sel.code  = 3'(k + 1);
                    o_sel.moist = i_item.pot_moisture[k];
                end
            end
        end
    end

endmodule

// File: hdl/iss_core.sv
// Sequencer state, per-tick stage advance, safety stop and result forming.
module iss_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  iss_pkg::t_item   i_item,
    input  iss_pkg::t_cfg    i_cfg,
    output iss_pkg::t_result o_res
);
    import iss_pkg::*;

    logic        r_active, n_active, p_active;
    logic [2:0]  r_target, n_target, p_target;
    t_stage      r_stage, n_stage, p_stage;
    logic        r_started, n_started, p_started;
    logic [15:0] r_timer, n_timer, p_timer;
    logic [6:0]  r_start_m, n_start_m, p_start_m;
    logic [4:0]  r_pend, p_pend;
    logic [15:0] r_since [NUM_TARGETS];
    logic [15:0] p_since [NUM_TARGETS];
    t_event      p_event;
    t_sel        w_sel;
    logic        w_safe;
    logic        w_humid;
    logic [15:0] w_timer_inc;
    logic [15:0] w_len;
    logic        w_done;
    logic [6:0]  w_now;
    logic        w_rise_ok;

    assign w_safe      = i_item.reservoir_has_water && !i_item.leak_detected;
    assign w_humid     = (r_target == HUMID_CODE);
    assign w_timer_inc = (r_timer == SAT_MAX) ? r_timer : r_timer + 16'd1;
    assign w_done      = r_started && (w_timer_inc >= w_len);
    assign w_now       = i_item.pot_moisture[2'(r_target[1:0] - 2'd1)];
    assign w_rise_ok   = {1'b0, w_now} > ({1'b0, r_start_m} + {1'b0, i_cfg.rise_threshold});

    always_comb begin
        case (r_stage)
            ST_MIX:    w_len = i_cfg.mix_sec;
            ST_TEST:   w_len = i_cfg.test_sec;
            ST_SETTLE: w_len = SETTLE_SEC;
            ST_MAIN:   w_len = w_humid ? i_cfg.humid_main_sec : i_cfg.main_sec;
            default:   w_len = SAT_MAX;
        endcase
    end

    // advance running stages and apply safety stop
    always_comb begin
        logic fin, go_valve, go_recheck;
        fin        = 1'b0;
        go_valve   = 1'b0;
        go_recheck = 1'b0;
        p_active   = r_active;
        p_target   = r_target;
        p_stage    = r_stage;
        p_started  = r_started;
        p_timer    = r_timer;
        p_start_m  = r_start_m;
        p_event    = EV_NONE;
        p_pend     = (r_pend | i_item.request_pulses) & PEND_MASK;
        for (int k = 0; k < NUM_TARGETS; k++) begin
            p_since[k] = (r_since[k] == SAT_MAX) ? r_since[k] : r_since[k] + 16'd1;
        end

        if (!w_safe || (r_active && i_item.wrap_near)) begin
            if (r_active) p_event = EV_ABORT;
            fin = 1'b1;
        end else if (r_active && (i_cfg.auto_enable || p_pend != '0)) begin
            case (r_stage)
                ST_MIX, ST_TEST, ST_SETTLE, ST_MAIN: begin
                    if (!r_started) begin
                        p_started = 1'b1;
                        p_timer   = '0;
                    end else if (!w_done) begin
                        p_timer = w_timer_inc;
                    end else begin
                        case (r_stage)
                            ST_MIX: go_valve = 1'b1;
                            ST_TEST: begin
                                p_stage   = ST_SETTLE;
                                p_started = 1'b1;
                                p_timer   = '0;
                            end
                            ST_SETTLE: go_recheck = 1'b1;
                            default: begin
                                fin     = 1'b1;
                                p_event = EV_FINISHED;
                            end
                        endcase
                    end
                end
                ST_VALVE:   go_valve = 1'b1;
                ST_RECHECK: go_recheck = 1'b1;
                default:    fin = 1'b1;
            endcase

            if (go_valve) begin
                if (i_item.valve_feedback) begin
                    p_stage   = w_humid ? ST_MAIN : ST_TEST;
                    p_started = 1'b1;
                    p_timer   = '0;
                end else if (r_stage == ST_MIX) begin
                    p_stage   = ST_VALVE;
                    p_started = 1'b0;
                    p_timer   = '0;
                end
            end
            if (go_recheck) begin
                if (w_rise_ok) begin
                    p_stage   = ST_MAIN;
                    p_started = 1'b1;
                    p_timer   = '0;
                end else begin
                    fin     = 1'b1;
                    p_event = EV_RECHECK;
                end
            end
        end

        if (fin) begin
            for (int k = 0; k < NUM_TARGETS; k++) begin
                if (r_target == 3'(k + 1)) p_since[k] = '0;
            end
            p_pend    = '0;
            p_active  = 1'b0;
            p_target  = '0;
            p_stage   = ST_IDLE;
            p_started = 1'b0;
            p_timer   = '0;
            p_start_m = '0;
        end
    end

    iss_select u_select (
        .i_cfg  (i_cfg),
        .i_item (i_item),
        .i_pend (p_pend),
        .i_since(p_since),
        .o_sel  (w_sel)
    );

    // start a new watering when idle
    always_comb begin
        n_active  = p_active;
        n_target  = p_target;
        n_stage   = p_stage;
        n_started = p_started;
        n_timer   = p_timer;
        n_start_m = p_start_m;
        if (p_event == EV_NONE && !p_active && w_safe && !i_item.wrap_near
                && (i_cfg.auto_enable || p_pend != '0) && w_sel.hit) begin
            n_active  = 1'b1;
            n_target  = w_sel.code;
            n_start_m = w_sel.moist;
            n_stage   = ST_MIX;
            n_started = 1'b1;
            n_timer   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_target  <= '0;
            r_stage   <= ST_IDLE;
            r_started <= 1'b0;
            r_timer   <= '0;
            r_start_m <= '0;
            r_pend    <= '0;
            for (int k = 0; k < NUM_TARGETS; k++) r_since[k] <= SAT_MAX;
        end else if (i_step) begin
            r_active  <= n_active;
            r_target  <= n_target;
            r_stage   <= n_stage;
            r_started <= n_started;
            r_timer   <= n_timer;
            r_start_m <= n_start_m;
            r_pend    <= p_pend;
            for (int k = 0; k < NUM_TARGETS; k++) r_since[k] <= p_since[k];
        end
    end

    always_comb begin
        o_res.mixer_on     = n_active && n_stage == ST_MIX && n_started;
        o_res.pump_on      = n_active && (n_stage == ST_TEST || n_stage == ST_MAIN) && n_started;
        o_res.valve_target = (n_active && n_stage >= ST_VALVE) ? n_target : 3'd0;
        o_res.stage        = n_active ? n_stage : ST_IDLE;
        o_res.event_res    = p_event;
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_stage == ST_IDLE && r_target == 3'd0))
        else $error("idle sequencer holds a stage or target");

    a_active_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_target != 3'd0 && r_stage != ST_IDLE))
        else $error("running sequencer without target or stage");

    a_no_rest_recheck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_stage != ST_RECHECK)
        else $error("recheck left pending across ticks");

    a_event_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.event_res != EV_NONE) |=> (!r_active && r_pend == '0))
        else $error("watering still running after end event");

endmodule

// File: hdl/irrigation_stage_sequencer.sv
// Top level of the irrigation stage sequencer: item input register, core, result register.
// Flow: an accepted item is held in the input register, and its result is registered in the result
// register when that register is free; a stalled result holds the item in the input register.
// Throughput: one item per cycle unless the result stalls; both registers decouple the sides.
// Reset (synchronous, active low): sequencer idle, requests cleared, since-last counters
// saturated, configuration registers at their defaults.
module irrigation_stage_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pot1..pot4_moisture[27:0], reservoir_has_water, leak_detected, humidifier_has_water,
    // valve_feedback, wrap_near, request_pulses[37:33], zero fill
    input  logic [iss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // mixer_on, pump_on, valve_target[4:2], stage[7:5], event_res[9:8], zero fill
    output logic [iss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [iss_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [iss_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [iss_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import iss_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_res;
    t_cfg    w_cfg;
    logic    w_step;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_out};

    iss_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (w_cfg)
    );

    iss_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_item (r_item),
        .i_cfg  (w_cfg),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= t_item'(s_axis_tdata[ITEM_W-1:0]);
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

endmodule
